### design/image_color_alpha_statistics_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_COLOR_ALPHA_STATISTICS_ASSERT_SVH
`define IMAGE_COLOR_ALPHA_STATISTICS_ASSERT_SVH

// same-cycle implication
`define ICAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/icas_pkg.sv
// ----------------------------------------------------------------------------
// icas_pkg
// Types and constants shared by the color and alpha statistics block.
// ----------------------------------------------------------------------------
package icas_pkg;

  localparam int COLOR_CAPACITY_DEF = 4096;
  localparam int PALETTE_DEPTH_DEF  = 256;
  localparam int QDEPTH             = 4;
  localparam int COUNT_FIELD_MAX    = 8191;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_RGB555   = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_RGBA1555 = 3'd4,
    FMT_INDEXED8 = 3'd5,
    FMT_INDEXED4 = 3'd6,
    FMT_UNUSED   = 3'd7
  } fmt_t;

  typedef enum logic [1:0] {
    ASRC_NONE,
    ASRC_DIRECT,
    ASRC_PAL
  } asrc_t;

  // one unit of work for the back end
  typedef struct packed {
    logic        wr_pal;
    logic        has_key;
    logic [31:0] key;
    asrc_t       asrc;
    logic [7:0]  aval;
    logic [7:0]  pidx;
    logic        last;
    logic        fmt_alpha;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT,
    ST_CLEAR
  } bstate_t;

endpackage

### design/image_color_alpha_statistics.sv
// ----------------------------------------------------------------------------
// image_color_alpha_statistics
// Distinct color count and alpha range over a frame of pixels.
//
//   channel  signals                                  direction
//   cfg      cfg_we, cfg_wdata                        write only
//   in       in_valid/in_ready, command .. frame_end  into block
//   out      out_valid/out_ready, colors_used .. max  out of block
//
// A palette write is done in the idle state; a pixel is looked up in the
// color hash table (one table read port), one more probe per collision,
// indexed4 twice. A result is emitted, then the table entries used are
// cleared. After reset the table, 2*2^clog2(COLOR_CAPACITY) entries (8192
// by default), is swept, while transactions only fill the operation queue.
// Front and back stall independently through a four-entry operation queue.
// ----------------------------------------------------------------------------
module image_color_alpha_statistics #(
  parameter int COLOR_CAPACITY = icas_pkg::COLOR_CAPACITY_DEF,
  parameter int PALETTE_DEPTH  = icas_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] pixel_word,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_alpha,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] colors_used,
  output logic        color_overflow,
  output logic [8:0]  alpha_used,
  output logic [7:0]  min_alpha,
  output logic [7:0]  max_alpha
);
  import icas_pkg::*;

  fmt_t    pixel_format;
  q_stat_t q_stat;
  op_t     push_op;
  op_t     head;
  logic    push;
  logic    pop;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA8888;
    end else if (cfg_we) begin
      pixel_format <= fmt_t'(cfg_wdata);
    end
  end

  icas_front u_front (
    .clk           (clk),
    .rst           (rst),
    .pixel_format  (pixel_format),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .pixel_word    (pixel_word),
    .palette_index (palette_index),
    .palette_alpha (palette_alpha),
    .frame_end     (frame_end),
    .q_stat        (q_stat),
    .push          (push),
    .push_op       (push_op)
  );

  icas_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  icas_back #(
    .COLOR_CAPACITY (COLOR_CAPACITY),
    .PALETTE_DEPTH  (PALETTE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .colors_used    (colors_used),
    .color_overflow (color_overflow),
    .alpha_used     (alpha_used),
    .min_alpha      (min_alpha),
    .max_alpha      (max_alpha)
  );

endmodule

### design/icas_front.sv
// ----------------------------------------------------------------------------
// icas_front
// Accepts input transactions and turns them into back-end operations.
// ----------------------------------------------------------------------------
module icas_front (
  input  logic               clk,
  input  logic               rst,
  input  icas_pkg::fmt_t     pixel_format,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [31:0]        pixel_word,
  input  logic [7:0]         palette_index,
  input  logic [7:0]         palette_alpha,
  input  logic               frame_end,
  input  icas_pkg::q_stat_t  q_stat,
  output logic               push,
  output icas_pkg::op_t      push_op
);
  import icas_pkg::*;

  logic pend;
  op_t  pend_op;
  op_t  op;
  op_t  hi_op;
  logic fmt_alpha;
  logic take;

  assign fmt_alpha = pixel_format inside {FMT_RGBA8888, FMT_RGBA1555,
                                          FMT_INDEXED8, FMT_INDEXED4};

  // classify the incoming transaction
  always_comb begin
    op           = '0;
    op.asrc      = ASRC_NONE;
    op.fmt_alpha = fmt_alpha;
    hi_op        = '0;
    hi_op.asrc   = ASRC_NONE;
    if (command == CMD_PALETTE) begin
      op.wr_pal = 1'b1;
      op.pidx   = palette_index;
      op.aval   = palette_alpha;
    end else begin
      op.last = frame_end;
      case (pixel_format)
        FMT_RGBA8888: begin
          op.has_key = 1'b1;
          op.key     = pixel_word;
          op.asrc    = ASRC_DIRECT;
          op.aval    = pixel_word[31:24];
        end
        FMT_RGB888: begin
          op.has_key = 1'b1;
          op.key     = {8'h00, pixel_word[23:0]};
        end
        FMT_RGB555, FMT_RGB565: begin
          op.has_key = 1'b1;
          op.key     = {16'h0000, pixel_word[15:0]};
        end
        FMT_RGBA1555: begin
          op.has_key = 1'b1;
          op.key     = {16'h0000, pixel_word[15:0]};
          op.asrc    = ASRC_DIRECT;
          op.aval    = pixel_word[15] ? 8'hff : 8'h00;
        end
        FMT_INDEXED8: begin
          op.has_key = 1'b1;
          op.key     = {24'h000000, pixel_word[7:0]};
          op.asrc    = ASRC_PAL;
          op.pidx    = pixel_word[7:0];
        end
        FMT_INDEXED4: begin
          op.has_key = 1'b1;
          op.key     = {28'h0000000, pixel_word[3:0]};
          op.asrc    = ASRC_PAL;
          op.pidx    = {4'h0, pixel_word[3:0]};
          op.last    = 1'b0;
        end
        default: begin
          op.has_key = 1'b0;
        end
      endcase
    end
    // second nibble of an indexed4 byte
    hi_op.has_key   = 1'b1;
    hi_op.key       = {28'h0000000, pixel_word[7:4]};
    hi_op.asrc      = ASRC_PAL;
    hi_op.pidx      = {4'h0, pixel_word[7:4]};
    hi_op.last      = frame_end;
    hi_op.fmt_alpha = fmt_alpha;
  end

  assign in_ready = !pend && !q_stat.full;
  assign take     = in_valid && in_ready;
  assign push     = pend ? !q_stat.full : take;
  assign push_op  = pend ? pend_op : op;

  // split state for two-pixel bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (pend) begin
      if (!q_stat.full) begin
        pend <= 1'b0;
      end
    end else if (take && command == CMD_PIXEL && pixel_format == FMT_INDEXED4) begin
      pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_op <= hi_op;
    end
  end

endmodule

### design/icas_queue.sv
// ----------------------------------------------------------------------------
// icas_queue
// Short operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module icas_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  icas_pkg::op_t      push_op,
  input  logic               pop,
  output icas_pkg::op_t      head,
  output icas_pkg::q_stat_t  q_stat
);
  import icas_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  op_t              slots [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QAW:0]     cnt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_op;
    end
  end

endmodule

### design/icas_back.sv
// ----------------------------------------------------------------------------
// icas_back
// Executes operations: palette writes, color set lookup and insert by
// linear probing, alpha tracking, result output and per-frame clearing.
// ----------------------------------------------------------------------------
`include "image_color_alpha_statistics_assert.svh"

module icas_back #(
  parameter int COLOR_CAPACITY = icas_pkg::COLOR_CAPACITY_DEF,
  parameter int PALETTE_DEPTH  = icas_pkg::PALETTE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  icas_pkg::q_stat_t  q_stat,
  input  icas_pkg::op_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        colors_used,
  output logic               color_overflow,
  output logic [8:0]         alpha_used,
  output logic [7:0]         min_alpha,
  output logic [7:0]         max_alpha
);
  import icas_pkg::*;

  localparam int CW     = $clog2(COLOR_CAPACITY + 1);
  localparam int LAW    = $clog2(COLOR_CAPACITY);
  localparam int AW     = $clog2(COLOR_CAPACITY) + 1;
  localparam int TBL    = 1 << AW;
  localparam int PW     = $clog2(PALETTE_DEPTH);
  localparam int NCHUNK = (32 + AW - 1) / AW;

  // memories
  logic [32:0]   tbl_mem [TBL];
  logic [AW-1:0] log_mem [COLOR_CAPACITY];
  logic [7:0]    pal_mem [PALETTE_DEPTH];

  bstate_t       state;
  bstate_t       state_next;
  op_t           cur;
  logic [AW-1:0] probe;
  logic [32:0]   tbl_q;
  logic [7:0]    pal_q;
  logic [AW-1:0] log_q;
  logic          log_v;
  logic [CW-1:0] count;
  logic          ovf;
  logic [255:0]  amap;
  logic [8:0]    acnt;
  logic [7:0]    alow;
  logic [7:0]    ahigh;
  logic [CW-1:0] clr_i;
  logic [CW-1:0] clr_n;
  logic [AW-1:0] init_a;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [32:0]   tbl_wdata;
  logic [AW-1:0] tbl_raddr;
  logic          pal_we;
  logic          pal_re;
  logic          resolve;
  logic          insert;
  logic          emit_go;
  logic          clr_rd;
  logic          clr_done;
  logic          hit;
  logic          slot_empty;
  logic          has_room;
  logic [7:0]    a_val;
  logic          a_en;
  logic [31:0]   cnt_ext;

  function automatic logic [AW-1:0] hash_key(input logic [31:0] k);
    logic [AW-1:0] h;
    h = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      h = h ^ AW'(k >> (i * AW));
    end
    return h;
  endfunction

  assign hit        = tbl_q[32] && (tbl_q[31:0] == cur.key);
  assign slot_empty = !tbl_q[32];
  assign has_room   = (count < CW'(COLOR_CAPACITY));
  assign clr_done   = (clr_i == clr_n) && !log_v;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (init_a == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty && !head.wr_pal) begin
          if (head.has_key) begin
            state_next = ST_LOOK;
          end else if (head.last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_LOOK: begin
        if (hit || slot_empty) begin
          state_next = cur.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    pal_we    = 1'b0;
    pal_re    = 1'b0;
    resolve   = 1'b0;
    insert    = 1'b0;
    emit_go   = 1'b0;
    clr_rd    = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = probe;
    tbl_wdata = {1'b1, cur.key};
    tbl_raddr = probe + 1'b1;
    case (state)
      ST_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = init_a;
        tbl_wdata = '0;
      end
      ST_IDLE: begin
        pop       = !q_stat.empty;
        pal_re    = 1'b1;
        pal_we    = !q_stat.empty && head.wr_pal &&
                    ({1'b0, head.pidx} < 9'(PALETTE_DEPTH));
        tbl_raddr = hash_key(head.key);
      end
      ST_LOOK: begin
        resolve = hit || slot_empty;
        insert  = slot_empty && has_room;
        tbl_we  = insert;
      end
      ST_EMIT: begin
        emit_go = !out_valid || out_ready;
      end
      ST_CLEAR: begin
        clr_rd    = (clr_i != clr_n);
        tbl_we    = log_v;
        tbl_waddr = log_q;
        tbl_wdata = '0;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // alpha of the current pixel
  always_comb begin
    a_en  = 1'b0;
    a_val = 8'h00;
    case (cur.asrc)
      ASRC_DIRECT: begin
        a_en  = 1'b1;
        a_val = cur.aval;
      end
      ASRC_PAL: begin
        a_en  = 1'b1;
        a_val = ({1'b0, cur.pidx} < 9'(PALETTE_DEPTH)) ? pal_q : 8'h00;
      end
      default: begin
        a_en = 1'b0;
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    tbl_q <= tbl_mem[tbl_raddr];
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    log_q <= log_mem[clr_i[LAW-1:0]];
    if (insert) begin
      log_mem[count[LAW-1:0]] <= probe;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_re) begin
      pal_q <= pal_mem[head.pidx[PW-1:0]];
    end
    if (pal_we) begin
      pal_mem[head.pidx[PW-1:0]] <= head.aval;
    end
  end

  // operation and probe registers
  always_ff @(posedge clk) begin
    probe <= tbl_raddr;
    if (pop) begin
      cur <= head;
    end
  end

  // control and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      init_a <= '0;
      count  <= '0;
      ovf    <= 1'b0;
      amap   <= '0;
      acnt   <= '0;
      alow   <= 8'hff;
      ahigh  <= 8'h00;
      clr_i  <= '0;
      clr_n  <= '0;
      log_v  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        init_a <= init_a + 1'b1;
      end
      if (resolve) begin
        if (insert) begin
          count <= count + 1'b1;
        end else if (slot_empty) begin
          ovf <= 1'b1;
        end
        if (a_en) begin
          if (!amap[a_val]) begin
            amap[a_val] <= 1'b1;
            acnt        <= acnt + 1'b1;
          end
          if (a_val < alow) begin
            alow <= a_val;
          end
          if (a_val > ahigh) begin
            ahigh <= a_val;
          end
        end
      end
      if (emit_go) begin
        clr_n <= count;
        clr_i <= '0;
        count <= '0;
        ovf   <= 1'b0;
        amap  <= '0;
        acnt  <= '0;
        alow  <= 8'hff;
        ahigh <= 8'h00;
      end
      if (clr_rd) begin
        clr_i <= clr_i + 1'b1;
      end
      log_v <= clr_rd;
    end
  end

  // result register
  assign cnt_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      colors_used    <= (cnt_ext > 32'(COUNT_FIELD_MAX)) ? 13'(COUNT_FIELD_MAX)
                                                         : cnt_ext[12:0];
      color_overflow <= ovf;
      alpha_used     <= cur.fmt_alpha ? acnt  : 9'd0;
      min_alpha      <= cur.fmt_alpha ? alow  : 8'hff;
      max_alpha      <= cur.fmt_alpha ? ahigh : 8'hff;
    end
  end

  // checks
  `ICAS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(COLOR_CAPACITY),
    "color count above capacity")
  `ICAS_ASSERT_NOW(a_insert_room, insert, has_room && state == ST_LOOK,
    "insert into full color set")
  `ICAS_ASSERT_NEXT(a_emit_clear, emit_go, state == ST_CLEAR && count == '0 && out_valid,
    "result not followed by clear")
  `ICAS_ASSERT_NOW(a_alpha_range, acnt != '0, alow <= ahigh,
    "alpha minimum above maximum")

endmodule
